@@ sv/bic_pkg.sv @@
`default_nettype none

package bic_pkg;

  // Largest frame side in pixels
  localparam int MAX_DIM = 4096;

  // Position counters hold 0 .. MAX_DIM-1
  localparam int POS_W = $clog2(MAX_DIM);
  // Size registers hold 0 .. 2*MAX_DIM-1 (clamped on use)
  localparam int SIZE_W = 13;
  // Pixel count reaches MAX_DIM * MAX_DIM
  localparam int COUNT_W = 2 * POS_W + 1;
  // Sum of positions below MAX_DIM * MAX_DIM * MAX_DIM
  localparam int SUM_W = 3 * POS_W;

  localparam int PIX_W = 8;
  localparam int CFG_INDEX_W = 2;

  // Serial divider step counter
  localparam int STEP_W = $clog2(POS_W + 1);

  // Register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = SIZE_W'(480);

  // Result beat: center_x, center_y, pixel_count packed, padded to bytes
  localparam int RES_W = 2 * POS_W + COUNT_W;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Clamp a size register to 1 .. MAX_DIM
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    begin
      r = v;
      if (v == '0) begin
        r = SIZE_W'(1);
      end else if (v > SIZE_W'(MAX_DIM)) begin
        r = SIZE_W'(MAX_DIM);
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

@@ sv/bic_accum.sv @@
`default_nettype none

module bic_accum
  import bic_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               beat,
  input  wire logic [PIX_W-1:0]   pixel,
  input  wire logic [SIZE_W-1:0]  frame_width,
  input  wire logic [SIZE_W-1:0]  frame_height,
  output logic                    frame_end,
  output logic [SUM_W-1:0]        sum_x_upd,
  output logic [SUM_W-1:0]        sum_y_upd,
  output logic [COUNT_W-1:0]      count_upd
);

  logic [POS_W-1:0]   col;
  logic [POS_W-1:0]   row;
  logic [SUM_W-1:0]   sum_x;
  logic [SUM_W-1:0]   sum_y;
  logic [COUNT_W-1:0] count;

  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic              set_pix;
  logic              row_end;

  // Effective frame size and end-of-row / end-of-frame detect
  always_comb begin
    w_eff     = clamp_size(frame_width);
    h_eff     = clamp_size(frame_height);
    set_pix   = (pixel != '0);
    row_end   = ((SIZE_W'(col) + SIZE_W'(1)) >= w_eff);
    frame_end = row_end && ((SIZE_W'(row) + SIZE_W'(1)) >= h_eff);
  end

  // Sums including the current pixel
  always_comb begin
    sum_x_upd = set_pix ? (sum_x + SUM_W'(col)) : sum_x;
    sum_y_upd = set_pix ? (sum_y + SUM_W'(row)) : sum_y;
    count_upd = set_pix ? (count + COUNT_W'(1)) : count;
  end

  // Position counters and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      sum_x <= '0;
      sum_y <= '0;
      count <= '0;
    end else if (beat) begin
      if (frame_end) begin
        col   <= '0;
        row   <= '0;
        sum_x <= '0;
        sum_y <= '0;
        count <= '0;
      end else begin
        sum_x <= sum_x_upd;
        sum_y <= sum_y_upd;
        count <= count_upd;
        if (row_end) begin
          col <= '0;
          row <= row + POS_W'(1);
        end else begin
          col <= col + POS_W'(1);
        end
      end
    end
  end

  // Frame end leaves a clean slate
  a_clear_after_frame: assert property (@(posedge clk) disable iff (rst)
    (beat && frame_end) |=> (col == '0 && row == '0 && count == '0 && sum_x == '0))
    else $error("accumulators not cleared after frame end");

  // Column stays inside the largest frame
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    (beat && !frame_end && !row_end) |=> (col != '0))
    else $error("column counter wrapped");

  // A set pixel raises the count, except at frame end where the count clears
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (beat && !frame_end && set_pix) |=> (count == $past(count) + COUNT_W'(1)))
    else $error("pixel count did not advance");

endmodule

`default_nettype wire

@@ sv/bic_div.sv @@
`default_nettype none

module bic_div
  import bic_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [SUM_W-1:0]   dividend,
  input  wire logic [COUNT_W-1:0] divisor,
  output div_stat_t               stat,
  output logic [POS_W-1:0]        quotient
);

  // The mean is below MAX_DIM, so the upper SUM_W-POS_W quotient bits are
  // zero and the partial remainder can start at the dividend's upper part.
  logic [COUNT_W-1:0] rem;
  logic [POS_W-1:0]   lo;
  logic [STEP_W-1:0]  steps;
  logic               busy;
  logic               done;
  logic [COUNT_W-1:0] dvs;

  logic [COUNT_W:0]   shifted;
  logic [COUNT_W+1:0] diff;
  logic               neg;

  // One restoring-division step
  always_comb begin
    shifted = {rem, lo[POS_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    neg     = diff[COUNT_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(POS_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= COUNT_W'(dividend[SUM_W-1:POS_W]);
      lo  <= dividend[POS_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= neg ? shifted[COUNT_W-1:0] : diff[COUNT_W-1:0];
      lo  <= {lo[POS_W-2:0], !neg};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = lo;

  // Never restarted mid-division
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

  // Done closes the run
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && steps == '0))
    else $error("divider done while still stepping");

  // Remainder stays below the divisor once started
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (busy && !start) |-> (rem < dvs))
    else $error("partial remainder out of range");

endmodule

`default_nettype wire

@@ sv/binary_image_centroid_unit.sv @@
`default_nettype none

// Centroid of the nonzero pixels of a raster frame. Pixels enter on the s_
// stream in raster order, one per beat, up to one per clock; frame_width and
// frame_height (register 0 and 1, clamped to 1..4096) set where rows and the
// frame end. At the last pixel of a frame one result beat is produced on the
// m_ stream: floored mean column and row, the pixel count, and in m_tuser a
// found flag (zero centroid when no pixel was set). The two means come from
// one shared bit-serial divider, run as start, 12 steps and done per mean,
// so after the last pixel the input is held off through both divisions and
// the load state (only the load state when the frame was empty), plus however
// long the previous result still waits on m_tready.
module binary_image_centroid_unit
  import bic_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Pixel stream
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [PIX_W-1:0]       s_tdata,    // [7:0] pixel
  // Result stream
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_DATA_W-1:0]       m_tdata,    // [11:0] center_x, [23:12] center_y,
                                                  // [48:24] pixel_count, rest zero
  output logic                        m_tuser,    // [0] found
  // Configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]      cfg_data
);

  localparam logic [2:0] S_ACC  = 3'd0;
  localparam logic [2:0] S_DIVX = 3'd1;
  localparam logic [2:0] S_DIVY = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;

  logic               beat;
  logic               frame_end;
  logic [SUM_W-1:0]   sum_x_upd;
  logic [SUM_W-1:0]   sum_y_upd;
  logic [COUNT_W-1:0] count_upd;

  logic [SUM_W-1:0]   sum_x_hold;
  logic [SUM_W-1:0]   sum_y_hold;
  logic [COUNT_W-1:0] count_hold;
  logic [POS_W-1:0]   qx;
  logic [POS_W-1:0]   qy;

  logic               div_go;
  logic [SUM_W-1:0]   div_dividend;
  div_stat_t          div_stat;
  logic [POS_W-1:0]   div_quot;

  logic               load;
  logic [POS_W-1:0]   out_x;
  logic [POS_W-1:0]   out_y;
  logic [COUNT_W-1:0] out_count;
  logic               out_found;
  logic               out_valid;

  assign s_tready  = (state == S_ACC);
  assign beat      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
      end
    end
  end

  bic_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .beat         (beat),
    .pixel        (s_tdata),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .frame_end    (frame_end),
    .sum_x_upd    (sum_x_upd),
    .sum_y_upd    (sum_y_upd),
    .count_upd    (count_upd)
  );

  assign div_dividend = (state == S_DIVX) ? sum_x_hold : sum_y_hold;

  bic_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_dividend),
    .divisor  (count_hold),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // Sequencer: accumulate, divide x, divide y, hand to output register
  assign load = (state == S_LOAD) && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_ACC: begin
        if (beat && frame_end) begin
          state_next = (count_upd == '0) ? S_LOAD : S_DIVX;
        end
      end
      S_DIVX: begin
        if (div_stat.done) begin
          state_next = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_stat.done) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (load) begin
          state_next = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_ACC;
      div_go <= 1'b0;
    end else begin
      state  <= state_next;
      div_go <= ((state == S_ACC) && beat && frame_end && (count_upd != '0)) ||
                ((state == S_DIVX) && div_stat.done);
    end
  end

  // Frame totals and the two means
  always_ff @(posedge clk) begin
    if (beat && frame_end) begin
      sum_x_hold <= sum_x_upd;
      sum_y_hold <= sum_y_upd;
      count_hold <= count_upd;
      qx         <= '0;
      qy         <= '0;
    end else begin
      if ((state == S_DIVX) && div_stat.done) begin
        qx <= div_quot;
      end
      if ((state == S_DIVY) && div_stat.done) begin
        qy <= div_quot;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x     <= qx;
      out_y     <= qy;
      out_count <= count_hold;
      out_found <= (count_hold != '0);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'({out_count, out_y, out_x});
  assign m_tuser  = out_found;

  // Pixels are only taken while the divider is idle
  a_acc_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> !div_stat.busy)
    else $error("pixel input open while divider busy");

  // Found flag agrees with the count it reports
  a_found_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_found == (out_count != '0)))
    else $error("found flag disagrees with pixel count");

  // Divider done only arrives in a divide state
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIVX || state == S_DIVY))
    else $error("divider done outside a divide state");

endmodule

`default_nettype wire
